[hdl/sst_pkg.sv]
// Shared constants and types for the sorted set table.
package sst_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic               found;
    logic               changed;
    logic               full_res;
    logic [COUNT_W-1:0] count;
  } sst_res_t;

  typedef struct packed {
    logic                     valid;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } sst_req_t;

endpackage

[hdl/sorted_set_table_unit.sv]
// Sorted set table: request channel, result register and engine.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order.
// in_*: one request per item; in_tuser carries the request kind
// (insert, delete, membership query), in_tdata the value.
// out_*: one result item per request: found, changed, full flag and
// the element count after the request.
// Work per request: a binary search over the memory takes a read, then a
// compare, for each probe; an insert or delete then moves each entry
// behind the found place by a read and a write, and last writes the new
// value or shrinks the count.
// The single-port read of the element memory is the reason: each
// probe and each moved entry needs its own read.
// in_tready is high only while the engine is idle; one item is in work
// at a time. A finished result sits in the output register, so the next
// request is taken while the receiver stalls; the engine then holds its
// result until the register frees.
// Reset empties the set (count zero); memory contents are not cleared.
module sorted_set_table_unit
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] found, [1] changed, [2] full_res, [9:3] count
);

  sst_req_t req;
  sst_res_t res;
  logic     req_ready;
  logic     res_valid;
  logic     res_ready;

  logic     out_valid_r, out_valid_nxt;
  sst_res_t out_res_r;

  assign req.valid    = in_tvalid & req_ready;
  assign req.req_type = in_tuser;
  assign req.value    = $signed(in_tdata);
  assign in_tready    = req_ready;

  sst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.count, out_res_r.full_res,
                       out_res_r.changed, out_res_r.found};

  // an accepted item keeps in_tready low in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine took a second item straight away");

  // a refused insert leaves the set unchanged and the table full
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.full_res |->
      !res.changed && !res.found && res.count == COUNT_W'(CAPACITY))
    else $error("full flag with inconsistent result");

  // a change is never reported together with the full flag
  a_change_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.changed |-> !res.full_res)
    else $error("changed and full together");

  // engine never finishes while the engine also reports idle
  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && req_ready))
    else $error("engine idle and done at once");

endmodule

[hdl/sst_engine.sv]
// Search and shift sequencer around the element memory of the sorted set.
module sst_engine
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sst_req_t req,
  output logic     req_ready,
  output logic     res_valid,
  input  logic     res_ready,
  output sst_res_t res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHR  = 3'd3;
  localparam logic [2:0] S_SHW  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata_r;

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               req_r, req_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic                     eq_r, eq_nxt;
  logic                     chg_r, chg_nxt, full_r, full_nxt;

  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic                     re;
  logic [ADDR_W-1:0]        raddr;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] wdata;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    val_nxt   = val_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    eq_nxt    = eq_r;
    chg_nxt   = chg_r;
    full_nxt  = full_r;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          req_nxt   = req.req_type;
          val_nxt   = req.value;
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          eq_nxt    = 1'b0;
          chg_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          re        = 1'b1;
          raddr     = mid[ADDR_W-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          // lo_r is the lower bound; eq_r tells whether it holds the value
          state_nxt = S_DONE;
          if (req_r == REQ_INSERT && !eq_r) begin
            if (cnt_r >= IDX_W'(CAPACITY)) begin
              full_nxt = 1'b1;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = S_SHR;
            end
          end else if (req_r == REQ_DELETE && eq_r) begin
            idx_nxt   = lo_r;
            state_nxt = S_SHR;
          end
        end
      end
      S_CMP: begin
        if (rdata_r < val_r) begin
          lo_nxt = mid_r + IDX_W'(1);
        end else begin
          hi_nxt = mid_r;
          eq_nxt = (rdata_r == val_r);
        end
        state_nxt = S_SRCH;
      end
      S_SHR: begin
        if (req_r == REQ_INSERT) begin
          if (idx_r == lo_r) begin
            we        = 1'b1;
            waddr     = idx_r[ADDR_W-1:0];
            wdata     = val_r;
            cnt_nxt   = cnt_r + IDX_W'(1);
            chg_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            re        = 1'b1;
            raddr     = ADDR_W'(idx_r - IDX_W'(1));
            state_nxt = S_SHW;
          end
        end else begin
          if ((idx_r + IDX_W'(1)) < cnt_r) begin
            re        = 1'b1;
            raddr     = ADDR_W'(idx_r + IDX_W'(1));
            state_nxt = S_SHW;
          end else begin
            cnt_nxt   = cnt_r - IDX_W'(1);
            chg_nxt   = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_SHW: begin
        we    = 1'b1;
        waddr = idx_r[ADDR_W-1:0];
        wdata = rdata_r;
        if (req_r == REQ_INSERT) begin
          idx_nxt = idx_r - IDX_W'(1);
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        state_nxt = S_SHR;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    req_r  <= req_nxt;
    val_r  <= val_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    idx_r  <= idx_nxt;
    eq_r   <= eq_nxt;
    chg_r  <= chg_nxt;
    full_r <= full_nxt;
  end

  assign req_ready    = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.found    = eq_r;
  assign res.changed  = chg_r;
  assign res.full_res = full_r;
  assign res.count    = COUNT_W'(cnt_r);

endmodule
